FILE: rtl/pdg_pkg.sv
package pdg_pkg;

  localparam int WORD_W     = 32;
  localparam int SAT_W      = 66;
  localparam int DRAG_W     = 17;
  localparam int GRAV_W     = 24;
  localparam int DEPTH_W    = 23;
  localparam int MOVE_W     = 24;
  localparam int EDGE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int K_W        = 31;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRAG    = 3'd0,
    REG_GRAVITY = 3'd1,
    REG_DEPTH   = 3'd2,
    REG_MOVE    = 3'd3,
    REG_LEFT    = 3'd4,
    REG_RIGHT   = 3'd5,
    REG_BOTTOM  = 3'd6
  } cfg_reg_t;

  // one particle as it moves down the pipe; pz carries the new depth after the depth stage
  typedef struct packed {
    word_t px;
    word_t py;
    word_t pz;
    word_t vx;
    word_t vy;
    word_t vz;
    logic  last;
  } part_t;

  function automatic word_t sat32(input logic signed [SAT_W-1:0] v);
    word_t r;
    if (v > SAT_W'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < SAT_W'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/pdg_vel.sv
module pdg_vel
  import pdg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  part_t                    in_part,
  input  logic        [DRAG_W-1:0] drag,
  input  logic signed [GRAV_W-1:0] gravity,
  output logic                     out_valid,
  output part_t                    out_part
);

  localparam int PROD_W = WORD_W + DRAG_W + 1;
  localparam int HALF   = 1 << (FRAC_BITS - 1);

  logic                     s1_valid_r, s2_valid_r, s3_valid_r;
  part_t                    s1_part_r, s2_part_r, s3_part_r;
  part_t                    s1_part_nxt, s3_part_nxt;
  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [PROD_W-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [DRAG_W:0]   drag_s;

  function automatic word_t rnd_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] s;
    s = ($signed({p[PROD_W-1], p}) + (PROD_W + 1)'(HALF)) >>> FRAC_BITS;
    return sat32(SAT_W'(s));
  endfunction

  assign drag_s = $signed({1'b0, drag});

  always_comb begin
    s1_part_nxt    = in_part;
    s1_part_nxt.vy = sat32(SAT_W'(in_part.vy) + SAT_W'(gravity));
  end

  assign px_nxt = PROD_W'(s1_part_r.vx) * PROD_W'(drag_s);
  assign py_nxt = PROD_W'(s1_part_r.vy) * PROD_W'(drag_s);
  assign pz_nxt = PROD_W'(s1_part_r.vz) * PROD_W'(drag_s);

  always_comb begin
    s3_part_nxt    = s2_part_r;
    s3_part_nxt.vx = rnd_sat(px_r);
    s3_part_nxt.vy = rnd_sat(py_r);
    s3_part_nxt.vz = rnd_sat(pz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_part_r <= s1_part_nxt;
    s2_part_r <= s1_part_r;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    pz_r      <= pz_nxt;
    s3_part_r <= s3_part_nxt;
  end

  assign out_valid = s3_valid_r;
  assign out_part  = s3_part_r;

endmodule

FILE: rtl/pdg_depth.sv
module pdg_depth
  import pdg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  part_t              in_part,
  input  logic [DEPTH_W-1:0] depth_step,
  output logic               out_valid,
  output part_t              out_part
);

  localparam int PROD_W = WORD_W + DEPTH_W;
  localparam int HALF   = 1 << (FRAC_BITS - 1);

  logic                     s1_valid_r, s2_valid_r;
  part_t                    s1_part_r, s2_part_r, s2_part_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [DEPTH_W:0]  depth_s;
  logic signed [PROD_W:0]   mv;

  assign depth_s  = $signed({1'b0, depth_step});
  assign prod_nxt = PROD_W'(in_part.vz) * PROD_W'(depth_s);

  always_comb begin
    mv             = ($signed({prod_r[PROD_W-1], prod_r}) + (PROD_W + 1)'(HALF)) >>> FRAC_BITS;
    s2_part_nxt    = s1_part_r;
    s2_part_nxt.pz = sat32(SAT_W'(s1_part_r.pz) + SAT_W'(mv));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_part_r <= in_part;
    prod_r    <= prod_nxt;
    s2_part_r <= s2_part_nxt;
  end

  assign out_valid = s2_valid_r;
  assign out_part  = s2_part_r;

endmodule

FILE: rtl/pdg_persp.sv
module pdg_persp
  import pdg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  part_t             in_part,
  input  logic [MOVE_W-1:0] move_scale,
  output logic              out_valid,
  output part_t             out_part,
  output logic [K_W-1:0]    out_k
);

  localparam int NUM_W   = (FRAC_BITS + 12 > WORD_W + 1) ? FRAC_BITS + 12 : WORD_W + 1;
  localparam int P_W     = ((FRAC_BITS > 21) ? FRAC_BITS : 21) + 2;
  localparam int PM_W    = P_W + MOVE_W;
  localparam int Q_W     = 22;
  localparam int A_W     = 29;
  localparam int R_W     = 26;
  localparam int HALF    = 1 << (FRAC_BITS - 1);
  localparam int ONE     = 1 << FRAC_BITS;
  localparam int PMIN    = (ONE + 50) / 100;
  localparam logic signed [NUM_W-1:0] Z_FAR     = NUM_W'(1000) <<< FRAC_BITS;
  localparam logic        [R_W-1:0]   RECIP_125 = 26'd34359738;
  localparam logic        [A_W-1:0]   DIV_125   = 29'd125;
  localparam logic signed [P_W:0]     ONE_S     = (P_W + 1)'(ONE);
  localparam logic signed [P_W:0]     PMIN_S    = (P_W + 1)'(PMIN);
  localparam logic        [K_W-1:0]   K_MAX     = '1;

  logic                     v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  part_t                    pt1_r, pt2_r, pt3_r, pt4_r, pt5_r, pt6_r;
  logic                     pos1_r, pos2_r, pos3_r;
  logic                     far1_r, far2_r, far3_r;
  logic [WORD_W-1:0]        u_r, u_nxt;
  logic [A_W-1:0]           a_r;
  logic [A_W+R_W-1:0]       qm_r, qm_nxt;
  logic [Q_W-1:0]           q_r, q_nxt, q0;
  logic [A_W-1:0]           r0;
  logic [P_W-1:0]           p_r, p_nxt;
  logic signed [P_W:0]      ps;
  logic [PM_W-1:0]          pm_r, pm_nxt;
  logic [PM_W:0]            kf;
  logic [K_W-1:0]           k_r, k_nxt;
  logic signed [WORD_W:0]   nz_ext;
  logic                     pos_nxt, far_nxt;

  // floor(num/1000) with num = 1000*2^F - z, via divide by 8 then by 125
  assign nz_ext  = (WORD_W + 1)'(in_part.pz);
  assign pos_nxt = in_part.pz > 0;
  assign far_nxt = NUM_W'(in_part.pz) >= Z_FAR;
  assign u_nxt   = pos_nxt ? WORD_W'(nz_ext - 33'sd1) : WORD_W'(-nz_ext);

  assign qm_nxt = (A_W + R_W)'(u_r[WORD_W-1:3]) * (A_W + R_W)'(RECIP_125);

  always_comb begin
    q0    = qm_r[WORD_W+Q_W-1:WORD_W];
    r0    = a_r - A_W'(q0) * DIV_125;
    q_nxt = (r0 >= DIV_125) ? q0 + Q_W'(1) : q0;
  end

  always_comb begin
    if (pos3_r) begin
      ps = ONE_S - (P_W + 1)'(1) - (P_W + 1)'(q_r);
    end else begin
      ps = ONE_S + (P_W + 1)'(q_r);
    end
    if (far3_r || ps < PMIN_S) begin
      p_nxt = P_W'(PMIN);
    end else begin
      p_nxt = ps[P_W-1:0];
    end
  end

  assign pm_nxt = PM_W'(p_r) * PM_W'(move_scale);

  always_comb begin
    kf    = ({1'b0, pm_r} + (PM_W + 1)'(HALF)) >> FRAC_BITS;
    k_nxt = (kf > (PM_W + 1)'(K_MAX)) ? K_MAX : kf[K_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    pt1_r  <= in_part;
    pos1_r <= pos_nxt;
    far1_r <= far_nxt;
    u_r    <= u_nxt;
    pt2_r  <= pt1_r;
    pos2_r <= pos1_r;
    far2_r <= far1_r;
    a_r    <= u_r[WORD_W-1:3];
    qm_r   <= qm_nxt;
    pt3_r  <= pt2_r;
    pos3_r <= pos2_r;
    far3_r <= far2_r;
    q_r    <= q_nxt;
    pt4_r  <= pt3_r;
    p_r    <= p_nxt;
    pt5_r  <= pt4_r;
    pm_r   <= pm_nxt;
    pt6_r  <= pt5_r;
    k_r    <= k_nxt;
  end

  assign out_valid = v6_r;
  assign out_part  = pt6_r;
  assign out_k     = k_r;

endmodule

FILE: rtl/pdg_move.sv
module pdg_move
  import pdg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  part_t                    in_part,
  input  logic        [K_W-1:0]    in_k,
  input  logic signed [EDGE_W-1:0] left_edge,
  input  logic signed [EDGE_W-1:0] right_edge,
  input  logic signed [EDGE_W-1:0] bottom_edge,
  output logic                     out_valid,
  output part_t                    out_part,
  output logic                     out_alive
);

  localparam int PROD_W = 2 * WORD_W - 1;
  localparam int HALF   = 1 << (FRAC_BITS - 1);
  localparam int CMP_W  = ((FRAC_BITS + EDGE_W > WORD_W) ? FRAC_BITS + EDGE_W : WORD_W) + 1;

  logic                     s1_valid_r, s2_valid_r, s3_valid_r;
  part_t                    s1_part_r, s2_part_r, s2_part_nxt, s3_part_r;
  logic signed [PROD_W-1:0] mx_r, my_r, mx_nxt, my_nxt;
  logic signed [K_W:0]      k_s;
  logic signed [PROD_W:0]   dx, dy;
  logic signed [CMP_W-1:0]  lim_l, lim_r, lim_b, nx_c, ny_c;
  logic                     alive_r, alive_nxt;

  assign k_s    = $signed({1'b0, in_k});
  assign mx_nxt = PROD_W'(in_part.vx) * PROD_W'(k_s);
  assign my_nxt = PROD_W'(in_part.vy) * PROD_W'(k_s);

  always_comb begin
    dx             = ($signed({mx_r[PROD_W-1], mx_r}) + (PROD_W + 1)'(HALF)) >>> FRAC_BITS;
    dy             = ($signed({my_r[PROD_W-1], my_r}) + (PROD_W + 1)'(HALF)) >>> FRAC_BITS;
    s2_part_nxt    = s1_part_r;
    s2_part_nxt.px = sat32(SAT_W'(s1_part_r.px) + SAT_W'(dx));
    s2_part_nxt.py = sat32(SAT_W'(s1_part_r.py) + SAT_W'(dy));
  end

  always_comb begin
    lim_l     = CMP_W'(left_edge) <<< FRAC_BITS;
    lim_r     = CMP_W'(right_edge) <<< FRAC_BITS;
    lim_b     = CMP_W'(bottom_edge) <<< FRAC_BITS;
    nx_c      = CMP_W'(s2_part_r.px);
    ny_c      = CMP_W'(s2_part_r.py);
    alive_nxt = !((nx_c < lim_l && s2_part_r.vx < 0) ||
                  (nx_c > lim_r && s2_part_r.vx > 0) ||
                  (ny_c > lim_b));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_part_r <= in_part;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    s2_part_r <= s2_part_nxt;
    s3_part_r <= s2_part_r;
    alive_r   <= alive_nxt;
  end

  assign out_valid = s3_valid_r;
  assign out_part  = s3_part_r;
  assign out_alive = alive_r;

endmodule

FILE: rtl/particle_drag_gravity_update_top.sv
// Particle motion update: gravity, drag, depth advance, perspective-scaled
// screen move and edge culling, one particle per item.
// Input: present a particle on in_* and raise start; it is taken on any
// clock edge where start is high and busy is low. busy stays low, so a new
// item can be taken every cycle.
// Output: each item yields one result on out_*, marked by out_strobe for
// exactly one cycle. Items leave in order. Throughput is one item per clock,
// fixed by the 14-stage pipeline (velocity 3, depth 2, perspective divide and
// scale 6, move and cull 3).
// The receiver has no back-pressure; it must take every strobed result.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 drag,
// 1 gravity step, 2 depth step, 3 move scale, 4 left, 5 right, 6 bottom edge);
// other indexes are ignored. Write only while no item is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// register values.
module particle_drag_gravity_update_top
  import pdg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    in_pos_x,
  input  logic signed [31:0]    in_pos_y,
  input  logic signed [31:0]    in_pos_z,
  input  logic signed [31:0]    in_vel_x,
  input  logic signed [31:0]    in_vel_y,
  input  logic signed [31:0]    in_vel_z,
  input  logic                  in_last_in_frame,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_strobe,
  output logic signed [31:0]    out_new_x,
  output logic signed [31:0]    out_new_y,
  output logic signed [31:0]    out_new_z,
  output logic signed [31:0]    out_new_vx,
  output logic signed [31:0]    out_new_vy,
  output logic signed [31:0]    out_new_vz,
  output logic                  out_alive,
  output logic                  out_end_of_set
);

  logic        [DRAG_W-1:0]  drag_factor_r;
  logic signed [GRAV_W-1:0]  gravity_step_r;
  logic        [DEPTH_W-1:0] depth_step_r;
  logic        [MOVE_W-1:0]  move_scale_r;
  logic signed [EDGE_W-1:0]  left_edge_r, right_edge_r, bottom_edge_r;

  part_t          in_part, vel_part, dep_part, per_part, mov_part;
  logic           in_valid, vel_valid, dep_valid, per_valid, mov_valid;
  logic [K_W-1:0] per_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_factor_r  <= 17'd63488;
      gravity_step_r <= 24'sd19661;
      depth_step_r   <= 23'd65536;
      move_scale_r   <= 24'd197;
      left_edge_r    <= 16'sd0;
      right_edge_r   <= 16'sd1023;
      bottom_edge_r  <= 16'sd767;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DRAG:    drag_factor_r  <= cfg_data[DRAG_W-1:0];
        REG_GRAVITY: gravity_step_r <= $signed(cfg_data[GRAV_W-1:0]);
        REG_DEPTH:   depth_step_r   <= cfg_data[DEPTH_W-1:0];
        REG_MOVE:    move_scale_r   <= cfg_data[MOVE_W-1:0];
        REG_LEFT:    left_edge_r    <= $signed(cfg_data[EDGE_W-1:0]);
        REG_RIGHT:   right_edge_r   <= $signed(cfg_data[EDGE_W-1:0]);
        REG_BOTTOM:  bottom_edge_r  <= $signed(cfg_data[EDGE_W-1:0]);
        default: ;
      endcase
    end
  end

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  always_comb begin
    in_part.px   = in_pos_x;
    in_part.py   = in_pos_y;
    in_part.pz   = in_pos_z;
    in_part.vx   = in_vel_x;
    in_part.vy   = in_vel_y;
    in_part.vz   = in_vel_z;
    in_part.last = in_last_in_frame;
  end

  pdg_vel #(.FRAC_BITS(FRAC_BITS)) u_vel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_part   (in_part),
    .drag      (drag_factor_r),
    .gravity   (gravity_step_r),
    .out_valid (vel_valid),
    .out_part  (vel_part)
  );

  pdg_depth #(.FRAC_BITS(FRAC_BITS)) u_depth (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (vel_valid),
    .in_part    (vel_part),
    .depth_step (depth_step_r),
    .out_valid  (dep_valid),
    .out_part   (dep_part)
  );

  pdg_persp #(.FRAC_BITS(FRAC_BITS)) u_persp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dep_valid),
    .in_part    (dep_part),
    .move_scale (move_scale_r),
    .out_valid  (per_valid),
    .out_part   (per_part),
    .out_k      (per_k)
  );

  pdg_move #(.FRAC_BITS(FRAC_BITS)) u_move (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (per_valid),
    .in_part     (per_part),
    .in_k        (per_k),
    .left_edge   (left_edge_r),
    .right_edge  (right_edge_r),
    .bottom_edge (bottom_edge_r),
    .out_valid   (mov_valid),
    .out_part    (mov_part),
    .out_alive   (out_alive)
  );

  assign out_strobe     = mov_valid;
  assign out_new_x      = mov_part.px;
  assign out_new_y      = mov_part.py;
  assign out_new_z      = mov_part.pz;
  assign out_new_vx     = mov_part.vx;
  assign out_new_vy     = mov_part.vy;
  assign out_new_vz     = mov_part.vz;
  assign out_end_of_set = mov_part.last;

endmodule
